// ----- rtl/rse_pkg.sv -----
// shared types, field widths and operation codes of the execute unit
package rse_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = 5;
  localparam int XLEN      = 32;
  localparam int PC_W      = 10;
  localparam int DADDR_W   = 12;
  localparam int FUNC_W    = 4;
  localparam int STATUS_W  = 2;

  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

  // operation codes
  localparam logic [FUNC_W-1:0] F_ADD   = 4'd0;
  localparam logic [FUNC_W-1:0] F_ADDI  = 4'd1;
  localparam logic [FUNC_W-1:0] F_SUB   = 4'd2;
  localparam logic [FUNC_W-1:0] F_JAL   = 4'd3;
  localparam logic [FUNC_W-1:0] F_BEQ   = 4'd4;
  localparam logic [FUNC_W-1:0] F_BLE   = 4'd5;
  localparam logic [FUNC_W-1:0] F_J     = 4'd6;
  localparam logic [FUNC_W-1:0] F_BNE   = 4'd7;
  localparam logic [FUNC_W-1:0] F_ECALL = 4'd8;
  localparam logic [FUNC_W-1:0] F_LA    = 4'd9;
  localparam logic [FUNC_W-1:0] F_LI    = 4'd10;
  localparam logic [FUNC_W-1:0] F_SW    = 4'd11;
  localparam logic [FUNC_W-1:0] F_LW    = 4'd12;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOLABEL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SYSCALL = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src_a_reg;
    logic [REG_IDX_W-1:0] src_b_reg;
    logic signed [XLEN-1:0] immediate;
    logic [PC_W-1:0]      instr_pc;
    logic [PC_W-1:0]      branch_target;
    logic [DADDR_W-1:0]   data_address;
    logic                 label_found;
  } cmd_t;

  typedef struct packed {
    logic                 redirect;
    logic [PC_W-1:0]      next_pc;
    logic                 reg_written;
    logic [REG_IDX_W-1:0] write_index;
    logic signed [XLEN-1:0] write_value;
    logic [STATUS_W-1:0]  status;
  } rsp_t;

  // register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

endpackage

// ----- rtl/rse_ifs.sv -----
// valid/ready channel interfaces for instruction and result words
interface rse_cmd_if import rse_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rse_rsp_if import rse_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/rse_regfile.sv -----
// register file: two registered read ports, one write port, reset valid bits
module rse_regfile import rse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] ra_idx,
  input  logic [REG_IDX_W-1:0] rb_idx,
  output logic [XLEN-1:0]      ra_data,
  output logic [XLEN-1:0]      rb_data,
  input  rf_wr_t               wr
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [XLEN-1:0]      ra_q;
  logic [XLEN-1:0]      rb_q;
  logic                 ra_vld;
  logic                 rb_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_q   <= mem[ra_idx];
      rb_q   <= mem[rb_idx];
      ra_vld <= valid[ra_idx];
      rb_vld <= valid[rb_idx];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  assign ra_data = ra_vld ? ra_q : '0;
  assign rb_data = rb_vld ? rb_q : '0;

endmodule

// ----- rtl/rse_dmem.sv -----
// data memory: single port, registered read, clearing sweep after reset
module rse_dmem import rse_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_en,
  input  logic                         req_we,
  input  logic [$clog2(MEM_WORDS)-1:0] req_addr,
  input  logic [XLEN-1:0]              req_wdata,
  output logic [XLEN-1:0]              rdata,
  output logic                         busy
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic            clr_active;
  logic [AW-1:0]   clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= '0;
    end else if (req_en && req_we) begin
      mem[req_addr] <= req_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req_en && !req_we) begin
      rdata <= mem[req_addr];
    end
  end

  assign busy = clr_active;

endmodule

// ----- rtl/riscv_subset_execute_unit_top.sv -----
// execute unit top: operand fetch, execute and result stage around two memories
// path: an accepted word goes through the fetch/execute register, then the result register; either can stall
// throughput: one instruction word per cycle while rsp.ready is high and no memory sweep runs
// back-to-back dependences are covered by forwarding from the result stage
// reset: pipeline empties, register file reads as zero at once
// reset: data memory clears in a sweep over all MEM_WORDS words with cmd.ready low
module riscv_subset_execute_unit_top import rse_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input logic       clk,
  input logic       rst,
  rse_cmd_if.sink   cmd,
  rse_rsp_if.source rsp
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [XLEN-1:0] MEM_BYTES = XLEN'(MEM_WORDS * 4);

  // handshake
  logic cmd_acc;
  logic s1_adv;
  logic s2_free;
  logic dm_busy;

  // fetch/execute stage
  logic           s1_valid;
  cmd_t           s1;
  logic           ovr_a_vld;
  logic           ovr_b_vld;
  logic [XLEN-1:0] ovr_a;
  logic [XLEN-1:0] ovr_b;

  // result stage
  logic                 s2_valid;
  logic                 s2_redirect;
  logic [PC_W-1:0]      s2_next_pc;
  logic                 s2_reg_written;
  logic [REG_IDX_W-1:0] s2_widx;
  logic [XLEN-1:0]      s2_value;
  logic                 s2_is_load;
  logic [STATUS_W-1:0]  s2_status;
  logic [XLEN-1:0]      s2_wval;

  // memory ports
  logic [XLEN-1:0] rf_a;
  logic [XLEN-1:0] rf_b;
  rf_wr_t          rf_wr;
  logic [XLEN-1:0] dm_rdata;
  logic            dm_en;
  logic            dm_we;

  // execute stage logic
  logic [XLEN-1:0]      va;
  logic [XLEN-1:0]      vb;
  logic [XLEN-1:0]      imm;
  logic [XLEN-1:0]      mem_addr;
  logic                 addr_ok;
  logic                 x_redirect;
  logic [PC_W-1:0]      x_next_pc;
  logic                 x_wr;
  logic [REG_IDX_W-1:0] x_widx;
  logic [XLEN-1:0]      x_value;
  logic                 x_is_load;
  logic                 x_mem;
  logic [STATUS_W-1:0]  x_status;

  assign s2_free = !s2_valid || rsp.ready;
  assign s1_adv  = s1_valid && s2_free;
  assign cmd.ready = !dm_busy && (!s1_valid || s1_adv);
  assign cmd_acc = cmd.valid && cmd.ready;

  // register file is read as the word is taken in
  rse_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd_acc),
    .ra_idx  (cmd.payload.src_a_reg),
    .rb_idx  (cmd.payload.src_b_reg),
    .ra_data (rf_a),
    .rb_data (rf_b),
    .wr      (rf_wr)
  );

  // write-back happens when the result word leaves
  assign s2_wval    = s2_is_load ? dm_rdata : s2_value;
  assign rf_wr.en   = s2_valid && rsp.ready && s2_reg_written;
  assign rf_wr.idx  = s2_widx;
  assign rf_wr.data = s2_wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      s1 <= cmd.payload;
    end
  end

  // catch a write that lands at or after the read edge of the word in fetch
  always_ff @(posedge clk) begin
    if (rst) begin
      ovr_a_vld <= 1'b0;
      ovr_b_vld <= 1'b0;
    end else if (cmd_acc) begin
      ovr_a_vld <= rf_wr.en && (rf_wr.idx == cmd.payload.src_a_reg);
      ovr_b_vld <= rf_wr.en && (rf_wr.idx == cmd.payload.src_b_reg);
    end else if (rf_wr.en && s1_valid) begin
      if (rf_wr.idx == s1.src_a_reg) begin
        ovr_a_vld <= 1'b1;
      end
      if (rf_wr.idx == s1.src_b_reg) begin
        ovr_b_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      ovr_a <= rf_wr.data;
      ovr_b <= rf_wr.data;
    end else if (rf_wr.en && s1_valid) begin
      if (rf_wr.idx == s1.src_a_reg) begin
        ovr_a <= rf_wr.data;
      end
      if (rf_wr.idx == s1.src_b_reg) begin
        ovr_b <= rf_wr.data;
      end
    end
  end

  // operand select: pending result first, then a caught write, then the file
  always_comb begin
    if (s2_valid && s2_reg_written && (s2_widx == s1.src_a_reg)) begin
      va = s2_wval;
    end else if (ovr_a_vld) begin
      va = ovr_a;
    end else begin
      va = rf_a;
    end
    if (s2_valid && s2_reg_written && (s2_widx == s1.src_b_reg)) begin
      vb = s2_wval;
    end else if (ovr_b_vld) begin
      vb = ovr_b;
    end else begin
      vb = rf_b;
    end
  end

  assign imm      = s1.immediate;
  assign mem_addr = va + imm;
  // word aligned, non-negative and inside the memory
  assign addr_ok  = !mem_addr[XLEN-1] && (mem_addr < MEM_BYTES) && (mem_addr[1:0] == 2'b00);

  always_comb begin
    x_redirect = 1'b0;
    x_next_pc  = '0;
    x_wr       = 1'b0;
    x_widx     = '0;
    x_value    = '0;
    x_is_load  = 1'b0;
    x_mem      = 1'b0;
    x_status   = ST_OK;
    unique case (s1.func)
      F_ADD: begin
        x_wr    = 1'b1;
        x_widx  = s1.dest_reg;
        x_value = va + vb;
      end
      F_ADDI: begin
        x_wr    = 1'b1;
        x_widx  = s1.dest_reg;
        x_value = mem_addr;
      end
      F_SUB: begin
        x_wr    = 1'b1;
        x_widx  = s1.dest_reg;
        x_value = va - vb;
      end
      F_JAL: begin
        if (s1.label_found) begin
          x_wr       = 1'b1;
          x_widx     = LINK_REG;
          x_value    = XLEN'(s1.instr_pc) + XLEN'(1);
          x_redirect = 1'b1;
          x_next_pc  = s1.branch_target;
        end
      end
      F_BEQ: begin
        if ((va == vb) && s1.label_found) begin
          x_redirect = 1'b1;
          x_next_pc  = s1.branch_target;
        end
      end
      F_BLE: begin
        if (($signed(va) <= $signed(vb)) && s1.label_found) begin
          x_redirect = 1'b1;
          x_next_pc  = s1.branch_target;
        end
      end
      F_J: begin
        if (s1.label_found) begin
          x_redirect = 1'b1;
          x_next_pc  = s1.branch_target;
        end
      end
      F_BNE: begin
        if ((va != vb) && s1.label_found) begin
          x_redirect = 1'b1;
          x_next_pc  = s1.branch_target;
        end
      end
      F_ECALL: begin
        x_status = ST_SYSCALL;
      end
      F_LA: begin
        if (s1.label_found) begin
          x_wr    = 1'b1;
          x_widx  = s1.dest_reg;
          x_value = XLEN'(s1.data_address);
        end else begin
          x_status = ST_NOLABEL;
        end
      end
      F_LI: begin
        x_wr    = 1'b1;
        x_widx  = s1.dest_reg;
        x_value = imm;
      end
      F_SW: begin
        if (addr_ok) begin
          x_mem = 1'b1;
        end else begin
          x_status = ST_FAULT;
        end
      end
      F_LW: begin
        if (addr_ok) begin
          x_mem     = 1'b1;
          x_wr      = 1'b1;
          x_widx    = s1.dest_reg;
          x_is_load = 1'b1;
        end else begin
          x_status = ST_FAULT;
        end
      end
      default: begin
      end
    endcase
  end

  // data memory access goes out as the word moves to the result stage
  assign dm_en = s1_adv && x_mem;
  assign dm_we = (s1.func == F_SW);

  rse_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk       (clk),
    .rst       (rst),
    .req_en    (dm_en),
    .req_we    (dm_we),
    .req_addr  (mem_addr[AW+1:2]),
    .req_wdata (vb),
    .rdata     (dm_rdata),
    .busy      (dm_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (rsp.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_redirect    <= x_redirect;
      s2_next_pc     <= x_next_pc;
      s2_reg_written <= x_wr;
      s2_widx        <= x_widx;
      s2_value       <= x_value;
      s2_is_load     <= x_is_load;
      s2_status      <= x_status;
    end
  end

  assign rsp.valid               = s2_valid;
  assign rsp.payload.redirect    = s2_redirect;
  assign rsp.payload.next_pc     = s2_next_pc;
  assign rsp.payload.reg_written = s2_reg_written;
  assign rsp.payload.write_index = s2_widx;
  assign rsp.payload.write_value = s2_wval;
  assign rsp.payload.status      = s2_status;

  // no instruction word is in flight while the memory sweep runs
  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    dm_busy |-> (!s1_valid && !s2_valid && !cmd.ready))
    else $error("instruction in flight during data memory sweep");

  // a jump or taken branch never reports a fault or a call
  a_redirect_ok: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_redirect) |-> (s2_status == ST_OK))
    else $error("redirect with non-ok status");

  // a faulting access writes no register
  a_fault_no_wb: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && (s2_status == ST_FAULT)) |-> !s2_reg_written)
    else $error("faulting access wrote a register");

  // a load moving into the result stage shows up there as a register-writing load
  a_load_read: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && x_is_load) |=> (s2_valid && s2_is_load && s2_reg_written))
    else $error("load result without memory read");

endmodule

// ----- tb/tb_riscv_subset_execute_unit_top.sv -----
// self-checking testbench for the execute unit: directed table, then random instruction words
module tb_riscv_subset_execute_unit_top;
  import rse_pkg::*;

  localparam int TB_MEM_WORDS = 1024;
  localparam int N_RANDOM     = 1250;
  localparam int N_CALM       = 150;      // tail of the run with no idling at all
  localparam int CYCLE_LIMIT  = 200000;

  // spare operation codes, the block treats them as no-ops
  localparam logic [FUNC_W-1:0] F_SPARE_LO = 4'd13;
  localparam logic [FUNC_W-1:0] F_SPARE_HI = 4'd15;

  typedef struct {
    cmd_t w;
    bit   typed;
    rsp_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  rse_cmd_if cmd_ch ();
  rse_rsp_if rsp_ch ();

  riscv_subset_execute_unit_top #(.MEM_WORDS(TB_MEM_WORDS)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // shadow state of the block
  logic [XLEN-1:0] gpr_shadow [REG_COUNT];
  logic [XLEN-1:0] dmem_shadow [TB_MEM_WORDS];

  rsp_t     pending_results [$];
  dir_row_t dir_rows [$];
  int       n_mismatch = 0;
  int       cycles = 0;
  bit       calm = 1'b0;
  rsp_t     got_res;
  rsp_t     want_res;

  initial begin
    foreach (gpr_shadow[k]) gpr_shadow[k] = '0;
    foreach (dmem_shadow[k]) dmem_shadow[k] = '0;
  end

  // executes one instruction word on the shadow state and returns its result word
  function automatic rsp_t exec_instr(cmd_t w);
    rsp_t r;
    logic [XLEN-1:0] va, vb, addr;
    logic addr_ok;
    r = '0;
    va = gpr_shadow[w.src_a_reg];
    vb = gpr_shadow[w.src_b_reg];
    addr = va + w.immediate;
    addr_ok = !addr[XLEN-1] && (addr < 32'(TB_MEM_WORDS * 4)) && (addr[1:0] == 2'b00);
    case (w.func)
      F_ADD: begin
        r.reg_written = 1'b1; r.write_index = w.dest_reg; r.write_value = va + vb;
      end
      F_ADDI: begin
        r.reg_written = 1'b1; r.write_index = w.dest_reg; r.write_value = va + w.immediate;
      end
      F_SUB: begin
        r.reg_written = 1'b1; r.write_index = w.dest_reg; r.write_value = va - vb;
      end
      F_JAL: if (w.label_found) begin
        r.reg_written = 1'b1;
        r.write_index = LINK_REG;
        r.write_value = {{(XLEN-PC_W){1'b0}}, w.instr_pc} + 32'd1;
        r.redirect = 1'b1;
        r.next_pc = w.branch_target;
      end
      F_BEQ: if (va == vb && w.label_found) begin
        r.redirect = 1'b1; r.next_pc = w.branch_target;
      end
      F_BLE: if ($signed(va) <= $signed(vb) && w.label_found) begin
        r.redirect = 1'b1; r.next_pc = w.branch_target;
      end
      F_J: if (w.label_found) begin
        r.redirect = 1'b1; r.next_pc = w.branch_target;
      end
      F_BNE: if (va != vb && w.label_found) begin
        r.redirect = 1'b1; r.next_pc = w.branch_target;
      end
      F_ECALL: r.status = ST_SYSCALL;
      F_LA: begin
        if (w.label_found) begin
          r.reg_written = 1'b1;
          r.write_index = w.dest_reg;
          r.write_value = {{(XLEN-DADDR_W){1'b0}}, w.data_address};
        end else begin
          r.status = ST_NOLABEL;
        end
      end
      F_LI: begin
        r.reg_written = 1'b1; r.write_index = w.dest_reg; r.write_value = w.immediate;
      end
      F_SW: begin
        if (addr_ok) dmem_shadow[addr[11:2]] = vb;
        else r.status = ST_FAULT;
      end
      F_LW: begin
        if (addr_ok) begin
          r.reg_written = 1'b1;
          r.write_index = w.dest_reg;
          r.write_value = dmem_shadow[addr[11:2]];
        end else begin
          r.status = ST_FAULT;
        end
      end
      default: ;
    endcase
    if (r.reg_written) gpr_shadow[r.write_index] = r.write_value;
    return r;
  endfunction

  function automatic cmd_t word_of(logic [FUNC_W-1:0] func, int rd, int ra, int rb,
                                   logic [XLEN-1:0] imm, int ipc, int tgt, int daddr,
                                   bit found);
    cmd_t w;
    w.func = func;
    w.dest_reg = rd[REG_IDX_W-1:0];
    w.src_a_reg = ra[REG_IDX_W-1:0];
    w.src_b_reg = rb[REG_IDX_W-1:0];
    w.immediate = imm;
    w.instr_pc = ipc[PC_W-1:0];
    w.branch_target = tgt[PC_W-1:0];
    w.data_address = daddr[DADDR_W-1:0];
    w.label_found = found;
    return w;
  endfunction

  function automatic rsp_t res_of(bit redir, int npc, bit wr, int widx,
                                  logic [XLEN-1:0] wval, logic [STATUS_W-1:0] st);
    rsp_t r;
    r.redirect = redir;
    r.next_pc = npc[PC_W-1:0];
    r.reg_written = wr;
    r.write_index = widx[REG_IDX_W-1:0];
    r.write_value = wval;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(cmd_t w, bit typed, rsp_t r);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.r = r;
    dir_rows = {dir_rows, row};
  endtask

  // idle rate for one stretch of the run: none, light or heavy
  function automatic int stall_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // random instruction word; load/store addresses are mostly aimed at valid words
  function automatic cmd_t rand_instr();
    cmd_t w;
    int unsigned pick;
    logic [XLEN-1:0] want;
    w = word_of(F_ADD, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 4092), $urandom_range(0, 7) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 10)      w.func = F_ADD;
    else if (pick < 18) w.func = F_ADDI;
    else if (pick < 24) w.func = F_SUB;
    else if (pick < 30) w.func = F_LI;
    else if (pick < 35) w.func = F_LA;
    else if (pick < 50) w.func = F_SW;
    else if (pick < 66) w.func = F_LW;
    else if (pick < 71) w.func = F_BEQ;
    else if (pick < 76) w.func = F_BNE;
    else if (pick < 81) w.func = F_BLE;
    else if (pick < 85) w.func = F_J;
    else if (pick < 89) w.func = F_JAL;
    else if (pick < 92) w.func = F_ECALL;
    else if (pick < 95) w.func = FUNC_W'($urandom_range(F_SPARE_LO, F_SPARE_HI));
    else                w.func = FUNC_W'($urandom_range(0, 15));
    // small immediates now and then so sums stay near interesting values
    if ((w.func == F_ADDI || w.func == F_LI) && $urandom_range(0, 3) == 0)
      w.immediate = 32'($urandom_range(0, 31)) - 32'd16;
    // equal operands make taken beq and untaken bne likely
    if ((w.func == F_BEQ || w.func == F_BNE || w.func == F_BLE) && $urandom_range(0, 2) == 0)
      w.src_b_reg = w.src_a_reg;
    if (w.func == F_SW || w.func == F_LW) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: want = 32'($urandom_range(0, 31)) * 4;   // hot region
        7: want = 32'($urandom_range(0, TB_MEM_WORDS - 1)) * 4;
        8: want = 32'($urandom_range(0, TB_MEM_WORDS * 4 + 64));      // any byte address, may be unaligned or past end
        default: want = 'x;
      endcase
      if (!$isunknown(want)) w.immediate = want - gpr_shadow[w.src_a_reg];
    end
    return w;
  endfunction

  // drive one word, wait for it to be taken, then record what it should produce
  task automatic send_word(cmd_t w, bit typed, rsp_t typed_res);
    rsp_t r;
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    r = exec_instr(w);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
  endtask

  task automatic idle_sender(int n);
    cmd_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    if (pending_results.size() != 0) begin
      cmd_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
    $display("[%0d] mismatch %0s: got %h want %h", cycles, what, got, want);
    n_mismatch++;
  endtask

  // result side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_res = rsp_ch.payload;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", got_res.write_value, '0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.redirect !== want_res.redirect)
          report_mismatch("redirect", XLEN'(got_res.redirect), XLEN'(want_res.redirect));
        if (got_res.next_pc !== want_res.next_pc)
          report_mismatch("next_pc", XLEN'(got_res.next_pc), XLEN'(want_res.next_pc));
        if (got_res.reg_written !== want_res.reg_written)
          report_mismatch("reg_written", XLEN'(got_res.reg_written),
                          XLEN'(want_res.reg_written));
        if (got_res.write_index !== want_res.write_index)
          report_mismatch("write_index", XLEN'(got_res.write_index),
                          XLEN'(want_res.write_index));
        if (got_res.write_value !== want_res.write_value)
          report_mismatch("write_value", got_res.write_value, want_res.write_value);
        if (got_res.status !== want_res.status)
          report_mismatch("status", XLEN'(got_res.status), XLEN'(want_res.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL riscv_subset_execute_unit_top");
      $finish;
    end
  end

  // result side back-pressure in bursts, with the rate re-picked by stall_rate as the run goes on
  initial begin
    int sink_pct;
    sink_pct = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycles % 200 == 0) sink_pct = stall_rate();
      if (!calm && $urandom_range(0, 99) < sink_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    int send_pct;
    cmd_t w;
    cmd_ch.valid <= 1'b0;
    cmd_ch.payload <= '0;
    send_pct = 0;

    // directed rows; typed results only where they read straight off the spec
    add_row(word_of(F_LI, 1, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 1), 1,
            res_of(0, 0, 1, 1, 32'h7FFFFFFF, ST_OK));
    add_row(word_of(F_LI, 2, 0, 0, 32'h80000000, 0, 0, 0, 1), 1,
            res_of(0, 0, 1, 2, 32'h80000000, ST_OK));
    // memory reads zero right after reset
    add_row(word_of(F_LW, 6, 0, 0, 32'd0, 0, 0, 0, 1), 1, res_of(0, 0, 1, 6, '0, ST_OK));
    add_row(word_of(F_ADDI, 3, 1, 0, 32'd1, 0, 0, 0, 1), 0, '0);   // wraps to min
    add_row(word_of(F_ADD, 4, 1, 1, 32'd0, 0, 0, 0, 1), 0, '0);
    add_row(word_of(F_SUB, 5, 2, 1, 32'd0, 0, 0, 0, 1), 0, '0);
    // last word of memory, store then load back
    add_row(word_of(F_SW, 0, 0, 1, 32'd4092, 0, 0, 0, 1), 1, res_of(0, 0, 0, 0, '0, ST_OK));
    add_row(word_of(F_LW, 7, 0, 0, 32'd4092, 0, 0, 0, 1), 0, '0);
    // faults: past the end, unaligned, negative, negative by wrap
    add_row(word_of(F_SW, 0, 0, 1, 32'd4096, 0, 0, 0, 1), 1, res_of(0, 0, 0, 0, '0, ST_FAULT));
    add_row(word_of(F_LW, 8, 0, 0, 32'd2, 0, 0, 0, 1), 1, res_of(0, 0, 0, 0, '0, ST_FAULT));
    add_row(word_of(F_LW, 8, 2, 0, 32'd0, 0, 0, 0, 1), 1, res_of(0, 0, 0, 0, '0, ST_FAULT));
    add_row(word_of(F_LW, 9, 1, 0, 32'd1, 0, 0, 0, 1), 1, res_of(0, 0, 0, 0, '0, ST_FAULT));
    // base plus offset wraps around to a valid address
    add_row(word_of(F_LW, 9, 1, 0, 32'h80000005, 0, 0, 0, 1), 0, '0);
    add_row(word_of(F_LA, 10, 0, 0, 32'd0, 0, 0, 4092, 1), 1,
            res_of(0, 0, 1, 10, 32'd4092, ST_OK));
    add_row(word_of(F_LA, 11, 0, 0, 32'd0, 0, 0, 4092, 0), 1,
            res_of(0, 0, 0, 0, '0, ST_NOLABEL));
    // jal links into the link register whatever dest_reg says
    add_row(word_of(F_JAL, 7, 0, 0, 32'd0, 1023, 5, 0, 1), 1,
            res_of(1, 5, 1, 31, 32'd1024, ST_OK));
    add_row(word_of(F_JAL, 7, 0, 0, 32'd0, 100, 5, 0, 0), 1, res_of(0, 0, 0, 0, '0, ST_OK));
    add_row(word_of(F_J, 0, 0, 0, 32'd0, 0, 1023, 0, 1), 1, res_of(1, 1023, 0, 0, '0, ST_OK));
    add_row(word_of(F_BEQ, 0, 0, 6, 32'd0, 0, 0, 0, 1), 0, '0);
    add_row(word_of(F_BNE, 0, 1, 2, 32'd0, 0, 777, 0, 1), 0, '0);
    add_row(word_of(F_BLE, 0, 2, 1, 32'd0, 0, 512, 0, 1), 0, '0);
    add_row(word_of(F_BLE, 0, 1, 2, 32'd0, 0, 512, 0, 1), 0, '0);
    add_row(word_of(F_ECALL, 3, 1, 2, 32'd0, 0, 0, 0, 1), 1, res_of(0, 0, 0, 0, '0, ST_SYSCALL));
    add_row(word_of(F_SPARE_HI, 3, 1, 2, 32'hFFFFFFFF, 0, 9, 9, 1), 1,
            res_of(0, 0, 0, 0, '0, ST_OK));
    // register 0 is an ordinary register
    add_row(word_of(F_LI, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 1), 1,
            res_of(0, 0, 1, 0, 32'hFFFFFFFF, ST_OK));
    add_row(word_of(F_ADD, 12, 0, 0, 32'd0, 0, 0, 0, 1), 0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].r);
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 12));
    end
    hold_until_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) send_pct = stall_rate();
      if (i == N_RANDOM / 2) hold_until_drained();
      if (i == N_RANDOM - N_CALM) calm = 1'b1;
      w = rand_instr();
      send_word(w, 1'b0, '0);
      if (!calm && $urandom_range(0, 99) < send_pct) idle_sender($urandom_range(1, 12));
    end
    hold_until_drained();
    // wait on to catch stray result words
    repeat (8) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("PASS riscv_subset_execute_unit_top");
    end else begin
      $display("FAIL riscv_subset_execute_unit_top");
    end
    $finish;
  end

endmodule
